@@ rtl/core/blss_pkg.sv @@
// shared constants, codes and types for the bounded lifo stack with search
package blss_pkg;

    // built geometry
    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;

    // search tree grouping
    localparam int GRP_W  = 3;
    localparam int GRP    = 1 << GRP_W;
    localparam int NGRP   = DEPTH / GRP;
    localparam int NGRP_W = IDX_W - GRP_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_PICK
    } state_t;

    // shift controls handed to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

endpackage

@@ rtl/core/blss_if.sv @@
// request and response channel interfaces
interface blss_req_if;
    import blss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [REQ_W-1:0]  req_type;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface blss_rsp_if;
    import blss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [STAT_W-1:0] status;
    logic signed [WORD_W-1:0] data;
    logic        [IDX_W-1:0]  found_index;
    logic        [CNT_W-1:0]  count;

    modport source (output valid, output status, output data, output found_index,
                    output count, input ready);
    modport sink   (input valid, input status, input data, input found_index,
                    input count, output ready);
endinterface

@@ rtl/core/blss_cell.sv @@
// one stack cell: holds a word, shifts with its neighbours, compares against the key
module blss_cell (
    input  logic                       clk,
    input  blss_pkg::cell_ctl_t        ctl,
    input  logic [blss_pkg::WORD_W-1:0] upper_word,
    input  logic [blss_pkg::WORD_W-1:0] lower_word,
    input  logic [blss_pkg::WORD_W-1:0] key,
    input  logic [blss_pkg::IDX_W-1:0]  cell_idx,
    input  logic [blss_pkg::CNT_W-1:0]  fill,
    output logic [blss_pkg::WORD_W-1:0] word,
    output logic                        hit
);
    import blss_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // push moves words away from the top, pop moves them back up
    always_comb
    begin
        word_next = word_reg;
        if (ctl.push)
        begin
            word_next = upper_word;
        end
        else if (ctl.pop)
        begin
            word_next = lower_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // match only counts while the cell is occupied
    assign hit  = ({1'b0, cell_idx} < fill) && (word_reg == key);
    assign word = word_reg;

endmodule

@@ rtl/core/blss_search.sv @@
// registered priority tree that finds the deepest matching cell
module blss_search (
    input  logic                        clk,
    input  logic                        start,
    input  logic [blss_pkg::DEPTH-1:0]  hits,
    input  logic [blss_pkg::CNT_W-1:0]  fill,
    output logic                        found,
    output logic [blss_pkg::IDX_W-1:0]  position
);
    import blss_pkg::*;

    logic [DEPTH-1:0] hit_vec_reg;
    logic [NGRP-1:0]  grp_any_reg;
    logic [GRP_W-1:0] grp_hi_reg [NGRP];
    logic [NGRP-1:0]  grp_any_next;
    logic [GRP_W-1:0] grp_hi_next [NGRP];
    logic [NGRP_W-1:0] sel_grp;
    logic [IDX_W-1:0]  cell_sel;
    logic [CNT_W-1:0]  pos_full;

    // capture the match vector on the accepted beat
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hit_vec_reg <= hits;
        end
    end

    // first level: highest set bit inside each group of eight
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_hi_next[g]  = '0;
            for (int b = 0; b < GRP; b++)
            begin
                if (hit_vec_reg[g*GRP + b])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_hi_next[g]  = GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_any_reg <= grp_any_next;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_hi_reg[g] <= grp_hi_next[g];
        end
    end

    // second level: highest group with a match
    always_comb
    begin
        sel_grp = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (grp_any_reg[g])
            begin
                sel_grp = NGRP_W'(g);
            end
        end
    end

    // deepest cell is the lowest position counted from the bottom
    assign found    = |grp_any_reg;
    assign cell_sel = {sel_grp, grp_hi_reg[sel_grp]};
    assign pos_full = fill - CNT_W'(1) - {1'b0, cell_sel};
    assign position = found ? pos_full[IDX_W-1:0] : '0;

endmodule

@@ rtl/core/bounded_lifo_stack_with_search.sv @@
// top level: shifting cell stack with sequencer, search tree and result register
// push, pop, peek, clear and unused codes: result registered at accept
// search: two-level match tree (match vector, group registers), then result register
// throughput: one request per cycle unless the response stalls; none taken during a search
// reset: fill count zero, capacity 64, response empty; cell words undefined, no clearing pass
module bounded_lifo_stack_with_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [blss_pkg::CNT_W-1:0]  cfg_wdata,
    blss_req_if.sink                    req,
    blss_rsp_if.source                  rsp
);
    import blss_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [CNT_W-1:0]  ucap;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [STAT_W-1:0] status_reg;
    logic [WORD_W-1:0] data_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              req_ready;
    logic              accept;
    logic              srch_start;
    logic              srch_done;
    logic              push_ok;
    logic              pop_ok;
    logic              is_search;
    logic              not_empty;
    cell_ctl_t         ctl;

    logic [WORD_W-1:0] cell_word [DEPTH];
    logic [DEPTH-1:0]  cell_hit;
    logic              srch_found;
    logic [IDX_W-1:0]  srch_pos;

    logic [STAT_W-1:0] imm_status;
    logic [WORD_W-1:0] imm_data;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CNT_W'(DEPTH);
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    assign ucap = (cap_reg < CNT_W'(DEPTH)) ? cap_reg : CNT_W'(DEPTH);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && is_search)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE: state_next = S_PICK;
            S_PICK:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req_ready = 1'b0;
        srch_done = 1'b0;
        case (state_reg)
            S_IDLE:  req_ready = !out_valid_reg || rsp.ready;
            S_MERGE: req_ready = 1'b0;
            S_PICK:  srch_done = 1'b1;
            default: req_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request decode
    assign req.ready  = req_ready;
    assign accept     = req.valid && req_ready;
    assign is_search  = (req.req_type == REQ_SEARCH);
    assign not_empty  = (fill_reg != '0);
    assign push_ok    = accept && (req.req_type == REQ_PUSH) && (fill_reg < ucap);
    assign pop_ok     = accept && (req.req_type == REQ_POP) && not_empty;
    assign srch_start = accept && is_search;
    assign ctl.push   = push_ok;
    assign ctl.pop    = pop_ok;

    // fill count
    always_comb
    begin
        fill_next = fill_reg;
        if (push_ok)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop_ok)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
        else if (accept && (req.req_type == REQ_CLEAR))
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // row of cells, top of stack in cell zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] upper_w;
        logic [WORD_W-1:0] lower_w;

        if (i == 0)
        begin : g_top
            assign upper_w = req.value;
        end
        else
        begin : g_mid
            assign upper_w = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bot
            assign lower_w = '0;
        end
        else
        begin : g_up
            assign lower_w = cell_word[i+1];
        end

        blss_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .upper_word (upper_w),
            .lower_word (lower_w),
            .key        (req.value),
            .cell_idx   (IDX_W'(i)),
            .fill       (fill_reg),
            .word       (cell_word[i]),
            .hit        (cell_hit[i])
        );
    end

    // search tree
    blss_search u_search (
        .clk      (clk),
        .start    (srch_start),
        .hits     (cell_hit),
        .fill     (fill_reg),
        .found    (srch_found),
        .position (srch_pos)
    );

    // immediate results for every request but search
    always_comb
    begin
        imm_status = STAT_OK;
        imm_data   = '0;
        case (req.req_type)
            REQ_PUSH:
            begin
                if (fill_reg >= ucap)
                begin
                    imm_status = STAT_FULL;
                end
            end
            REQ_POP, REQ_PEEK:
            begin
                if (not_empty)
                begin
                    imm_data = cell_word[0];
                end
                else
                begin
                    imm_status = STAT_EMPTY;
                end
            end
            REQ_CLEAR: imm_status = STAT_OK;
            default:   imm_status = STAT_OK;
        endcase
    end

    // response beat register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((accept && !is_search) || srch_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (srch_done)
        begin
            status_reg <= srch_found ? STAT_OK : STAT_NOTFOUND;
            data_reg   <= '0;
            index_reg  <= srch_pos;
            count_reg  <= fill_reg;
        end
        else if (accept && !is_search)
        begin
            status_reg <= imm_status;
            data_reg   <= imm_data;
            index_reg  <= '0;
            count_reg  <= fill_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.data        = data_reg;
    assign rsp.found_index = index_reg;
    assign rsp.count       = count_reg;

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the bounded lifo stack with search: directed and random requests
`timescale 1ns / 1ps

module testbench;
    import blss_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 6;
    localparam int ITEM_GOAL  = 2000;

    // one reply as the block should deliver it
    typedef struct packed {
        logic        [STAT_W-1:0] status;
        logic signed [WORD_W-1:0] data;
        logic        [IDX_W-1:0]  found_index;
        logic        [CNT_W-1:0]  count;
    } stack_reply_t;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_SEARCH} req_mix_t;

    // shadow stack, reply queue and checks
    class stack_checker;
        logic signed [WORD_W-1:0] words [DEPTH];
        int                       held;
        int                       capacity;
        stack_reply_t             pending_replies [$];
        int                       errors;
        int                       n_checked;
        int                       n_full;
        int                       n_empty;
        int                       n_notfound;
        int                       peak_fill;

        function new();
            held       = 0;
            capacity   = DEPTH;
            errors     = 0;
            n_checked  = 0;
            n_full     = 0;
            n_empty    = 0;
            n_notfound = 0;
            peak_fill  = 0;
        endfunction

        // work out the reply to an accepted request and update the shadow stack
        function void predict_request(logic [REQ_W-1:0] code, logic signed [WORD_W-1:0] word);
            stack_reply_t r;
            int           lim;
            int           i;
            r   = '{status: STAT_OK, data: '0, found_index: '0, count: '0};
            lim = (capacity < DEPTH) ? capacity : DEPTH;
            case (code)
                REQ_PUSH:
                    if (held >= lim)
                        r.status = STAT_FULL;
                    else
                    begin
                        words[held] = word;
                        held++;
                    end
                REQ_POP, REQ_PEEK:
                    if (held == 0)
                        r.status = STAT_EMPTY;
                    else
                    begin
                        r.data = words[held-1];
                        if (code == REQ_POP)
                            held--;
                    end
                REQ_CLEAR:
                    held = 0;
                REQ_SEARCH:
                begin
                    // walk down so the lowest match wins
                    r.status = STAT_NOTFOUND;
                    for (i = held - 1; i >= 0; i--)
                        if (words[i] == word)
                        begin
                            r.status      = STAT_OK;
                            r.found_index = i[IDX_W-1:0];
                        end
                end
                default: ;
            endcase
            r.count = held[CNT_W-1:0];
            if (held > peak_fill)
                peak_fill = held;
            pending_replies.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // compare one delivered reply with the oldest prediction
        task check_reply(logic [STAT_W-1:0] status, logic signed [WORD_W-1:0] data,
                         logic [IDX_W-1:0] found_index, logic [CNT_W-1:0] count);
            stack_reply_t e;
            if (pending_replies.size() == 0)
            begin
                report($sformatf("reply with nothing outstanding (status %0d)", status));
                return;
            end
            e = pending_replies.pop_front();
            n_checked++;
            if (e.status == STAT_FULL)
                n_full++;
            if (e.status == STAT_EMPTY)
                n_empty++;
            if (e.status == STAT_NOTFOUND)
                n_notfound++;
            if (status !== e.status)
                report($sformatf("status %0d, wanted %0d", status, e.status));
            if (data !== e.data)
                report($sformatf("data %0d, wanted %0d", data, e.data));
            if (found_index !== e.found_index)
                report($sformatf("found_index %0d, wanted %0d", found_index, e.found_index));
            if (count !== e.count)
                report($sformatf("count %0d, wanted %0d", count, e.count));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CNT_W-1:0]    cfg_wdata;

    blss_req_if req_ch();
    blss_rsp_if rsp_ch();

    stack_checker sb = new();

    bit no_gaps;
    bit long_hold_due;
    int n_sent;
    int n_cap_writes;
    int n_long_holds;

    bounded_lifo_stack_with_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap before a request: mostly none, some short, a few long
    function int sender_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // words biased towards repeats and extremes
    function logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 7)) - 4;
            1:
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return -1;
                    default: return 0;
                endcase
            default: return $urandom();
        endcase
    endfunction

    // drive one request and note it once the block takes the beat
    task automatic send_request(input logic [REQ_W-1:0] code,
                                input logic signed [WORD_W-1:0] word);
        int gap;
        gap = sender_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= code;
        req_ch.value    <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.predict_request(code, word);
        n_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    // wait for every outstanding reply, then let the pipeline settle
    task automatic wait_drained();
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_capacity(input int cap);
        wait_drained();
        @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= cap[CNT_W-1:0];
        sb.capacity = cap & ((1 << CNT_W) - 1);
        n_cap_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // fixed corner cases
    task automatic run_directed();
        // empty stack behaviour
        send_request(REQ_POP, 0);
        send_request(REQ_PEEK, 0);
        send_request(REQ_SEARCH, 32'sh7fff_ffff);
        // extremes and a duplicate, search must return the lowest
        send_request(REQ_PUSH, 32'sh7fff_ffff);
        send_request(REQ_PUSH, 32'sh8000_0000);
        send_request(REQ_PUSH, -1);
        send_request(REQ_PUSH, 0);
        send_request(REQ_PUSH, -1);
        send_request(REQ_PEEK, 0);
        send_request(REQ_SEARCH, -1);
        send_request(REQ_SEARCH, 32'sh8000_0000);
        send_request(REQ_SEARCH, 12345);
        // unused codes change nothing
        send_request(3'd5, -1);
        send_request(3'd6, 32'sh8000_0000);
        send_request(3'd7, 32'sh7fff_ffff);
        send_request(REQ_POP, 0);
        send_request(REQ_POP, 0);
        send_request(REQ_CLEAR, -1);
        send_request(REQ_POP, 0);
        stop_sending();
        // zero capacity refuses every push
        write_capacity(0);
        send_request(REQ_PUSH, 7);
        send_request(REQ_SEARCH, 7);
        stop_sending();
        // small capacity fills quickly
        write_capacity(2);
        send_request(REQ_PUSH, 11);
        send_request(REQ_PUSH, 22);
        send_request(REQ_PUSH, 33);
        send_request(REQ_SEARCH, 22);
        stop_sending();
    endtask

    function logic [REQ_W-1:0] pick_code(req_mix_t mix);
        int r;
        int push_lim;
        int pop_lim;
        int peek_lim;
        r = $urandom_range(0, 99);
        if (r < 2)
            return REQ_W'($urandom_range(5, 7));
        if (r < 3)
            return REQ_CLEAR;
        case (mix)
            MIX_FILL:     begin push_lim = 70; pop_lim = 80; peek_lim = 87; end
            MIX_DRAIN:    begin push_lim = 25; pop_lim = 70; peek_lim = 80; end
            MIX_BALANCED: begin push_lim = 45; pop_lim = 75; peek_lim = 85; end
            default:      begin push_lim = 30; pop_lim = 45; peek_lim = 50; end
        endcase
        if (r < push_lim)
            return REQ_PUSH;
        if (r < pop_lim)
            return REQ_POP;
        if (r < peek_lim)
            return REQ_PEEK;
        return REQ_SEARCH;
    endfunction

    // a run of random requests; searches mostly look for held words
    task automatic run_phase(input req_mix_t mix, input int n_items);
        logic [REQ_W-1:0]         code;
        logic signed [WORD_W-1:0] word;
        repeat (n_items)
        begin
            code = pick_code(mix);
            if (code == REQ_SEARCH && sb.held > 0 && $urandom_range(0, 3) != 0)
                word = sb.words[$urandom_range(0, sb.held - 1)];
            else
                word = pick_word();
            send_request(code, word);
        end
        stop_sending();
    endtask

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                hold_left     = LONG_HOLD;
                n_long_holds++;
            end
            else if (hold_left == 0 && !no_gaps && $urandom_range(0, 7) == 0)
                hold_left = stall_len();
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // reply checking at the rising edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_reply(rsp_ch.status, rsp_ch.data, rsp_ch.found_index, rsp_ch.count);
        end
    end

    // watchdog on cycles without any beat
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
                 IDLE_LIMIT, sb.pending_replies.size());
        $display("DONE: errors detected");
        $finish;
    end

    // main sequence
    initial
    begin
        int       caps [12];
        req_mix_t mixes [4];
        int       phase;
        int       cap;
        caps  = '{64, 127, 8, 64, 0, 1, 64, 100, 3, 65, 33, 64};
        mixes = '{MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_SEARCH};

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_PUSH;
        req_ch.value    = '0;
        no_gaps         = 1'b0;
        long_hold_due   = 1'b0;
        n_sent          = 0;
        n_cap_writes    = 0;
        n_long_holds    = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        phase = 0;
        while (n_sent < ITEM_GOAL)
        begin
            cap = (phase < 12) ? caps[phase] : $urandom_range(0, 127);
            write_capacity(cap);
            no_gaps = (phase % 5 == 3) || (phase == 2);
            // make the block back up against a stalled receiver
            if (phase == 2)
                long_hold_due = 1'b1;
            run_phase(mixes[phase % 4], $urandom_range(100, 180));
            phase++;
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);

        $display("covered: %0d requests, %0d replies, %0d capacity writes, peak fill %0d",
                 n_sent, sb.n_checked, n_cap_writes, sb.peak_fill);
        $display("covered: %0d full, %0d empty, %0d not found, %0d long receiver holds",
                 sb.n_full, sb.n_empty, sb.n_notfound, n_long_holds);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
